/* hdl/encoder_angle_unwrap_velocity_defines.svh */
// Assertion macros for the encoder unwrap / velocity block
`ifndef ENCODER_ANGLE_UNWRAP_VELOCITY_DEFINES_SVH
`define ENCODER_ANGLE_UNWRAP_VELOCITY_DEFINES_SVH

`ifndef SYNTH
`define EAUV_ASSERT(label, clk_i, rst_ni, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
		else $error(msg);
`define EAUV_NEVER(label, clk_i, rst_ni, cond, msg) \
	`EAUV_ASSERT(label, clk_i, rst_ni, !(cond), msg)
`else
`define EAUV_ASSERT(label, clk_i, rst_ni, prop, msg)
`define EAUV_NEVER(label, clk_i, rst_ni, cond, msg)
`endif

`endif

/* hdl/eauv_pkg.sv */
`default_nettype none
package eauv_pkg;

	localparam int CptBits = 16;
	localparam int RawW    = 16;
	localparam int TsW     = 24;
	localparam int RateW   = 27;
	localparam int AngW    = 32;
	localparam int TurnW   = 16;
	localparam int ProdW   = AngW + RateW;
	// numerator padded to an even width: the divider retires two bits a cycle
	localparam int NumW    = ProdW + (ProdW % 2);
	localparam int DivSteps = NumW / 2;
	localparam int DivCntW = $clog2(DivSteps);
	localparam int QuotW   = AngW + 1;
	localparam int WrapW   = ((CptBits > RawW) ? CptBits : RawW) + 4;

	localparam logic [RawW-1:0] RawMask = RawW'((64'd1 << CptBits) - 64'd1);
	localparam logic [WrapW-1:0] WrapLimit = WrapW'(64'd4 << CptBits);

	localparam logic [RateW-1:0] TickRateRst  = RateW'(9000000);
	localparam logic [TsW-1:0]   MaxIntRst    = TsW'(4500000);
	localparam logic [TsW-1:0]   FallbackRst  = TsW'(9000);

	localparam logic [AngW-1:0] VelPosSat = {1'b0, {(AngW-1){1'b1}}};
	localparam logic [AngW-1:0] VelNegSat = {1'b1, {(AngW-1){1'b0}}};

	typedef enum logic [1:0] {
		OpInit     = 2'd0,
		OpAngle    = 2'd1,
		OpVelocity = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CfgTickRate    = 2'd0,
		CfgMaxInterval = 2'd1,
		CfgFallback    = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		StIdle,
		StUnwrap,
		StMul,
		StDiv,
		StEmit
	} state_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic             ovf;
		logic [QuotW-1:0] quot;
	} div_res_t;

endpackage
`default_nettype wire

/* hdl/eauv_div.sv */
`default_nettype none
`include "encoder_angle_unwrap_velocity_defines.svh"
module eauv_div (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [eauv_pkg::NumW-1:0] numer,
	input  wire logic [eauv_pkg::TsW-1:0]  denom,
	output eauv_pkg::div_res_t          res
);
	import eauv_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [NumW-1:0]    num_q;
	logic [TsW-1:0]     den_q;
	logic [TsW-1:0]     rem_q;
	logic [QuotW-1:0]   quot_q;
	logic               ovf_q;

	logic [TsW:0]   trial1, trial2;
	logic           ge1, ge2;
	logic [TsW-1:0] rem1, rem2;

	// two restoring steps per cycle
	always_comb begin
		trial1 = {rem_q, num_q[NumW-1]};
		ge1    = trial1 >= {1'b0, den_q};
		rem1   = ge1 ? TsW'(trial1 - {1'b0, den_q}) : TsW'(trial1);
		trial2 = {rem1, num_q[NumW-2]};
		ge2    = trial2 >= {1'b0, den_q};
		rem2   = ge2 ? TsW'(trial2 - {1'b0, den_q}) : TsW'(trial2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DivCntW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= numer;
			den_q  <= denom;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			num_q  <= {num_q[NumW-3:0], 2'b00};
			rem_q  <= rem2;
			// anything pushed past the top quotient bit saturates later
			ovf_q  <= ovf_q | (|quot_q[QuotW-1:QuotW-2]);
			quot_q <= {quot_q[QuotW-3:0], ge1, ge2};
		end
	end

	assign res = {busy_q, done_q, ovf_q, quot_q};

	`EAUV_NEVER(a_no_restart, clk, arst_n, start && busy_q, "divider restarted while busy")
	`EAUV_ASSERT(a_rem_below, clk, arst_n, busy_q |-> (rem_q < den_q), "remainder too large")
	`EAUV_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q), "done without a run")

endmodule
`default_nettype wire

/* hdl/encoder_angle_unwrap_velocity.sv */
// Channel  Dir  Group                        Contents
// s_       in   tvalid/tready/tdata/tuser    item: angle sample, timestamp, opcode
// m_       out  tvalid/tready/tdata/tuser    result: multi-turn angle, velocity, flag
// cfg_     in   valid/ready/index/data       register writes, always ready
//
// Init and angle items: accept, unwrap, emit; s_tready is high only in idle, so one item is in flight.
// Velocity items: unwrap, a multiply state, then the divider (30 steps, 2 quotient bits each),
// then emit.
// Reset clears the turn state and loads the register defaults; no clearing pass.
// The result waits in the output register; the next item is taken meanwhile and
// holds at emit only if that register is still full.
`default_nettype none
`include "encoder_angle_unwrap_velocity_defines.svh"
module encoder_angle_unwrap_velocity (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [15:0] raw_angle, [39:16] timestamp
	input  wire logic [1:0]  s_tuser,   // [1:0] opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [31:0] full_angle, [63:32] velocity
	output logic [0:0]       m_tuser,   // [0] velocity_valid
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [26:0] cfg_data
);
	import eauv_pkg::*;

	state_t state_q, state_d;

	logic [RateW-1:0] tick_rate_q;
	logic [TsW-1:0]   max_int_q;
	logic [TsW-1:0]   fallback_q;

	logic [1:0]      op_q;
	logic [RawW-1:0] raw_q;
	logic [TsW-1:0]  ts_q;

	logic [RawW-1:0]  prev_raw_q;
	logic [TurnW-1:0] turn_q;
	logic [AngW-1:0]  ang_last_q;
	logic [TsW-1:0]   time_last_q;

	logic [AngW-1:0] angle_q;
	logic [AngW-1:0] mag_q;
	logic            neg_q;
	logic [TsW-1:0]  den_q;
	logic            vvalid_q;

	logic            m_tvalid_q;
	logic [AngW-1:0] m_angle_q;
	logic [AngW-1:0] m_vel_q;
	logic            m_vvalid_q;

	logic accept, load_out, div_start;
	div_res_t div_res;

	// unwrap
	logic [RawW-1:0]  raw_m;
	logic [RawW:0]    dlt, dlt_mag;
	logic [WrapW-1:0] mag5;
	logic             wrap;
	logic [TurnW-1:0] turn_upd;
	logic [AngW-1:0]  turn_ext;
	logic [AngW-1:0]  angle_upd;

	// velocity preparation
	logic [TsW-1:0]  ticks, den_sel;
	logic [AngW-1:0] diff;

	logic [ProdW-1:0] prod;
	logic [NumW-1:0]  numer;
	logic [AngW-1:0]  vel_sat;

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		raw_m    = raw_q & RawMask;
		dlt      = {1'b0, raw_m} - {1'b0, prev_raw_q};
		dlt_mag  = dlt[RawW] ? (~dlt + 1'b1) : dlt;
		mag5     = (WrapW'(dlt_mag) << 2) + WrapW'(dlt_mag);
		wrap     = mag5 > WrapLimit;
		turn_upd = turn_q;
		if (wrap) begin
			turn_upd = dlt[RawW] ? (turn_q + 1'b1) : (turn_q - 1'b1);
		end
		if (op_q == OpInit) begin
			turn_upd = '0;
		end
		turn_ext  = {{(AngW-TurnW){turn_upd[TurnW-1]}}, turn_upd};
		angle_upd = (turn_ext << CptBits) + {{(AngW-RawW){1'b0}}, raw_m};

		ticks = time_last_q - ts_q;
		diff  = angle_upd - ang_last_q;
		den_sel = ticks;
		if (ticks == '0 || ticks > max_int_q) begin
			den_sel = fallback_q;
		end
		if (den_sel == '0) begin
			den_sel = TsW'(1);
		end
	end

	// one multiply, registered inside the divider
	assign prod  = ProdW'(mag_q) * ProdW'(tick_rate_q);
	assign numer = NumW'(prod) + NumW'(den_q >> 1);

	always_comb begin
		if (neg_q) begin
			if (div_res.ovf || div_res.quot[QuotW-1] ||
			    (div_res.quot[AngW-1] && (|div_res.quot[AngW-2:0]))) begin
				vel_sat = VelNegSat;
			end else begin
				vel_sat = '0 - div_res.quot[AngW-1:0];
			end
		end else begin
			if (div_res.ovf || div_res.quot[QuotW-1] || div_res.quot[AngW-1]) begin
				vel_sat = VelPosSat;
			end else begin
				vel_sat = div_res.quot[AngW-1:0];
			end
		end
	end

	eauv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (numer),
		.denom  (den_q),
		.res    (div_res)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			StIdle: begin
				if (accept) state_d = StUnwrap;
			end
			StUnwrap: begin
				state_d = (op_q == OpVelocity) ? StMul : StEmit;
			end
			StMul: begin
				state_d = StDiv;
			end
			StDiv: begin
				if (div_res.done) state_d = StEmit;
			end
			StEmit: begin
				if (!m_tvalid_q || m_tready) state_d = StIdle;
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			StIdle:   s_tready  = 1'b1;
			StMul:    div_start = 1'b1;
			StEmit:   load_out  = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			tick_rate_q <= TickRateRst;
			max_int_q   <= MaxIntRst;
			fallback_q  <= FallbackRst;
			prev_raw_q  <= '0;
			turn_q      <= '0;
			ang_last_q  <= '0;
			time_last_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CfgTickRate:    tick_rate_q <= cfg_data[RateW-1:0];
					CfgMaxInterval: max_int_q   <= cfg_data[TsW-1:0];
					CfgFallback:    fallback_q  <= cfg_data[TsW-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == StUnwrap) begin
				prev_raw_q <= raw_m;
				turn_q     <= turn_upd;
				case (op_q)
					OpInit: begin
						ang_last_q  <= angle_upd;
						time_last_q <= '0;
					end
					OpVelocity: begin
						ang_last_q  <= angle_upd;
						time_last_q <= ts_q;
					end
					default: begin
					end
				endcase
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			raw_q <= s_tdata[RawW-1:0];
			ts_q  <= s_tdata[RawW+TsW-1:RawW];
		end
		if (state_q == StUnwrap) begin
			angle_q  <= angle_upd;
			vvalid_q <= op_q == OpVelocity;
			neg_q    <= diff[AngW-1];
			mag_q    <= diff[AngW-1] ? ('0 - diff) : diff;
			den_q    <= den_sel;
		end
		if (load_out) begin
			m_angle_q  <= angle_q;
			m_vel_q    <= vvalid_q ? vel_sat : '0;
			m_vvalid_q <= vvalid_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {m_vel_q, m_angle_q};
	assign m_tuser[0] = m_vvalid_q;

	`EAUV_ASSERT(a_done_in_div, clk, arst_n, div_res.done |-> (state_q == StDiv), "stray done")
	`EAUV_NEVER(a_vel_zero, clk, arst_n, m_tvalid && !m_tuser[0] && (|m_tdata[63:32]), "bad vel")
	`EAUV_NEVER(a_idle_div_busy, clk, arst_n, s_tready && div_res.busy, "taken while dividing")

endmodule
`default_nettype wire

/* tb/tb_encoder_angle_unwrap_velocity.sv */
`default_nettype none
module tb_encoder_angle_unwrap_velocity;
	import eauv_pkg::*;

	// field values outside the package enums
	localparam logic [1:0] OpSpare  = 2'd3;
	localparam logic [1:0] CfgSpare = 2'd3;

	localparam int TurnCounts   = 1 << 16;
	localparam int SettleCycles = 48;
	localparam int HoldCycles   = 400;
	localparam int DrainLimit   = 200000;

	typedef struct packed {
		logic [31:0] angle;
		logic [31:0] speed;
		logic        speed_ok;
	} motion_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [15:0] raw_angle, [39:16] timestamp
	logic [1:0]  s_tuser;   // [1:0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [31:0] full_angle, [63:32] velocity
	logic [0:0]  m_tuser;   // [0] velocity_valid
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [26:0] cfg_data;

	// shadow of the block's registers and tracking state
	logic [26:0] cur_tick_rate    = TickRateRst;
	logic [23:0] cur_max_interval = MaxIntRst;
	logic [23:0] cur_fallback     = FallbackRst;
	logic [15:0] trk_prev_raw     = '0;
	logic [15:0] trk_turns        = '0;
	logic [31:0] trk_vel_angle    = '0;
	logic [23:0] trk_vel_time     = '0;

	motion_t expected_motion[$];
	int      mismatches   = 0;
	bit      rx_eager     = 0;
	bit      rx_calm      = 0;
	bit      tx_eager     = 0;
	bit      hold_request = 0;

	encoder_angle_unwrap_velocity u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("encoder_angle_unwrap_velocity test failed");
		$finish;
	end

	function automatic motion_t predict_motion(input logic [1:0] op, input logic [15:0] raw,
			input logic [23:0] ts);
		motion_t         res;
		int              d;
		int              mag;
		logic [23:0]     ticks;
		logic [31:0]     diff;
		logic [31:0]     neg_diff;
		longint unsigned abs_diff;
		longint unsigned span;
		longint unsigned q;
		res = '0;
		if (op == OpInit) begin
			trk_prev_raw  = raw;
			trk_turns     = '0;
			res.angle     = {16'h0, raw};
			trk_vel_angle = res.angle;
			trk_vel_time  = '0;
		end else begin
			d = int'(raw) - int'(trk_prev_raw);
			mag = (d < 0) ? -d : d;
			// a jump of more than four fifths of a turn is a pass through zero
			if (mag * 5 > 4 * TurnCounts)
				trk_turns = (d > 0) ? trk_turns - 16'd1 : trk_turns + 16'd1;
			trk_prev_raw = raw;
			res.angle = {trk_turns, 16'h0} + {16'h0, raw};
			if (op == OpVelocity) begin
				ticks = trk_vel_time - ts;
				if (ticks == 0 || ticks > cur_max_interval)
					ticks = cur_fallback;
				if (ticks == 0)
					ticks = 24'd1;
				diff = res.angle - trk_vel_angle;
				neg_diff = -diff;
				abs_diff = diff[31] ? neg_diff : diff;
				span = ticks;
				q = (abs_diff * cur_tick_rate + span / 2) / span;
				if (diff[31]) begin
					if (q > 64'h8000_0000)
						q = 64'h8000_0000;
					res.speed = -q[31:0];
				end else begin
					if (q > 64'h7FFF_FFFF)
						q = 64'h7FFF_FFFF;
					res.speed = q[31:0];
				end
				res.speed_ok  = 1'b1;
				trk_vel_angle = res.angle;
				trk_vel_time  = ts;
			end
		end
		return res;
	endfunction

	function automatic void note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %h, got %h", $time, what, want, got);
	endfunction

	function automatic int sender_gap();
		int r;
		if (tx_eager)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 45);
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [15:0] raw,
			input logic [23:0] ts, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ts, raw};
		s_tuser  <= op;
		do @(posedge clk); while (s_tready !== 1'b1);
		expected_motion.push_back(predict_motion(op, raw, ts));
	endtask

	// holds cfg_valid high; the caller drops it after the last transfer
	task automatic cfg_put(input logic [1:0] idx, input logic [26:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CfgTickRate:    cur_tick_rate = data;
			CfgMaxInterval: cur_max_interval = data[23:0];
			CfgFallback:    cur_fallback = data[23:0];
			default: ;
		endcase
	endtask

	task automatic write_regs(input logic [26:0] rate, input logic [26:0] max_ticks,
			input logic [26:0] fallback);
		cfg_put(CfgTickRate, rate);
		cfg_put(CfgMaxInterval, max_ticks);
		cfg_put(CfgFallback, fallback);
		cfg_put(CfgSpare, 27'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		int waited;
		s_tvalid <= 1'b0;
		for (waited = 0; expected_motion.size() != 0 && waited < DrainLimit; waited++)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		motion_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (expected_motion.size() == 0) begin
				note_mismatch("result with nothing outstanding, angle", 32'h0, m_tdata[31:0]);
			end else begin
				want = expected_motion.pop_front();
				if (m_tdata[31:0] !== want.angle)
					note_mismatch("full_angle", want.angle, m_tdata[31:0]);
				if (m_tdata[63:32] !== want.speed)
					note_mismatch("velocity", want.speed, m_tdata[63:32]);
				if (m_tuser[0] !== want.speed_ok)
					note_mismatch("velocity_valid", 32'(want.speed_ok), 32'(m_tuser[0]));
			end
		end
	end

	initial begin : drive_ready
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 149) == 0)
				rx_calm = !rx_calm;
			if (hold_request) begin
				m_tready <= 1'b0;
				for (stall = 0; stall < HoldCycles; stall++)
					@(posedge clk);
				hold_request = 0;
			end else if (rx_eager || rx_calm || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b0;
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60)
					: $urandom_range(1, 3);
				repeat (stall) @(posedge clk);
			end
		end
	end

	task automatic test_unwrap_edges();
		send_item(OpInit, 16'h0000, 24'h000000, sender_gap());
		// backwards through zero, then forwards again
		send_item(OpAngle, 16'hFFFF, 24'hFFFFFF, sender_gap());
		send_item(OpAngle, 16'h0000, 24'h000000, sender_gap());
		// 0xCCCC is just short of the wrap threshold, 0xCCCD just past it
		send_item(OpSpare, 16'hCCCC, 24'h555555, sender_gap());
		send_item(OpAngle, 16'h0000, 24'hAAAAAA, sender_gap());
		send_item(OpAngle, 16'hCCCD, 24'h000001, sender_gap());
		send_item(OpSpare, 16'h0000, 24'h800000, sender_gap());
		send_item(OpAngle, 16'h8000, 24'h7FFFFF, sender_gap());
		wait_drained();
	endtask

	task automatic test_velocity_intervals();
		send_item(OpInit, 16'h8000, 24'hABCDEF, sender_gap());
		// init zeroes the reference time, so a zero stamp gives an empty interval
		send_item(OpVelocity, 16'h8100, 24'h000000, sender_gap());
		send_item(OpVelocity, 16'h8200, 24'hFFFFFF, sender_gap());
		send_item(OpVelocity, 16'h7000, 24'h7FFFFF, sender_gap());
		send_item(OpVelocity, 16'h7100, 24'h7FDCD7, sender_gap());
		send_item(OpAngle, 16'h0500, 24'h123456, sender_gap());
		send_item(OpVelocity, 16'hF000, 24'h7F0000, sender_gap());
		wait_drained();
	endtask

	task automatic test_register_extremes();
		write_regs('0, 27'd4500000, 27'd9000);
		send_item(OpVelocity, 16'h1234, 24'h123456, sender_gap());
		wait_drained();
		// zero fallback: every rejected interval becomes a single tick
		write_regs(27'd9000000, 27'd1, '0);
		send_item(OpVelocity, 16'h2234, 24'h123451, sender_gap());
		send_item(OpVelocity, 16'h2200, 24'h123451, sender_gap());
		wait_drained();
		write_regs('1, '1, '1);
		send_item(OpInit, 16'h0000, 24'h000000, sender_gap());
		send_item(OpVelocity, 16'h4000, 24'hFFFFFF, sender_gap());
		send_item(OpVelocity, 16'h0000, 24'hFFFFFE, sender_gap());
		send_item(OpVelocity, 16'h0000, 24'hFFFFFE, sender_gap());
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		int n;
		write_regs(27'd9000000, 27'd4500000, 27'd9000);
		hold_request = 1;
		for (n = 0; n < 30; n++)
			send_item((n % 3 == 0) ? OpVelocity : OpAngle, 16'($urandom()),
				24'($urandom()), 0);
		wait_drained();
	endtask

	// three steps per turn: twenty turns up, then down through zero into negative counts
	task automatic test_turn_counter_wrap();
		int k;
		rx_eager = 1;
		send_item(OpInit, 16'h0000, 24'($urandom()), 0);
		for (k = 0; k < 20; k++) begin
			send_item(OpAngle, 16'h7000, 24'($urandom()), 0);
			send_item(OpAngle, 16'hE000, 24'($urandom()), 0);
			send_item(OpAngle, 16'h0000, 24'($urandom()), 0);
			if (k == 0)
				send_item(OpVelocity, 16'h0000, 24'($urandom()), 0);
		end
		for (k = 0; k < 40; k++) begin
			send_item(OpAngle, 16'hE000, 24'($urandom()), 0);
			send_item(OpAngle, 16'h7000, 24'($urandom()), 0);
			send_item(OpAngle, 16'h0000, 24'($urandom()), 0);
			if (k == 19 || k == 39)
				send_item(OpVelocity, 16'h0000, 24'($urandom()), 0);
		end
		send_item(OpVelocity, 16'h1000, 24'($urandom()), 0);
		rx_eager = 0;
		wait_drained();
	endtask

	task automatic test_random_motion();
		int          phase;
		int          n;
		int          r;
		int          step;
		logic [1:0]  op;
		logic [15:0] gen_raw;
		logic [23:0] gen_ts;
		gen_raw = 16'($urandom());
		gen_ts  = 24'($urandom());
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: write_regs(27'($urandom_range(1, 100000000)),
					27'($urandom_range(20000, 16777215)), 27'($urandom_range(1, 100000)));
				1: write_regs('1, '1, '1);
				2: write_regs(27'd1, 27'd1, 27'd1);
				3: write_regs('0, '0, '0);
				default: write_regs(27'($urandom()), 27'($urandom()), 27'($urandom()));
			endcase
			for (n = 0; n < 120; n++) begin
				if (n % 25 == 0)
					tx_eager = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < 4)
					op = OpInit;
				else if (r < 8)
					op = OpSpare;
				else if (r < 50)
					op = OpAngle;
				else
					op = OpVelocity;
				// mostly smooth shaft motion, some fast moves, some noise
				r = $urandom_range(0, 99);
				if (r < 70) begin
					step = $urandom_range(0, 2000);
					gen_raw = gen_raw + 16'(step - 1000);
				end else if (r < 85) begin
					step = $urandom_range(0, 16000);
					gen_raw = gen_raw + 16'(step - 8000);
				end else begin
					gen_raw = 16'($urandom());
				end
				r = $urandom_range(0, 99);
				if (r < 70)
					gen_ts = gen_ts - 24'($urandom_range(1, 20000));
				else if (r < 80)
					gen_ts = gen_ts - 24'($urandom_range(0, 1));
				else if (r < 90)
					gen_ts = gen_ts - 24'($urandom_range(4000000, 16777215));
				else
					gen_ts = 24'($urandom());
				send_item(op, gen_raw, gen_ts, sender_gap());
			end
			tx_eager = 0;
			wait_drained();
		end
	endtask

	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_unwrap_edges();
		test_velocity_intervals();
		test_register_extremes();
		test_output_backpressure();
		test_turn_counter_wrap();
		test_random_motion();
		if (expected_motion.size() != 0)
			$display("%0d results never arrived", expected_motion.size());
		if (mismatches == 0 && expected_motion.size() == 0)
			$display("encoder_angle_unwrap_velocity test passed");
		else
			$display("encoder_angle_unwrap_velocity test failed");
		$finish;
	end

endmodule
`default_nettype wire
